@@ design/mrh_pkg.sv @@
package mrh_pkg;

  localparam int KEY_BITS     = 64;
  localparam int VALUE_BITS   = 20;
  localparam int BUCKET_DEPTH = 256;
  localparam int NUM_BUCKETS  = 65;
  localparam int COUNT_BITS   = 15;

  localparam int IDX_BITS   = $clog2(BUCKET_DEPTH);
  localparam int FILL_BITS  = $clog2(BUCKET_DEPTH + 1);
  localparam int BKT_BITS   = $clog2(NUM_BUCKETS);
  localparam int DATA_DEPTH = NUM_BUCKETS * (1 << IDX_BITS);
  localparam int ADDR_BITS  = BKT_BITS + IDX_BITS;
  localparam int WORD_BITS  = KEY_BITS + VALUE_BITS;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  // 1-based position of the highest set bit, zero for zero
  function automatic logic [BKT_BITS-1:0] top_bit(input logic [KEY_BITS-1:0] x);
    logic [BKT_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (x[i]) n = BKT_BITS'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ design/mrh_ram.sv @@
module mrh_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ design/monotone_radix_heap.sv @@
// Monotone radix heap of (key, value) requests. Items live in one synchronous RAM split into
// 65 buckets of BUCKET_DEPTH entries; bucket fills live in a second small RAM, qualified by
// per-bucket nonzero flags so that reset and clear need no clearing pass. Requests are
// handled one at a time. Push reads the bucket fill, then writes the item; clear drops all
// flags. Pop and peek read the fill of bucket 0, then its last item. If bucket 0 is empty,
// a refill first scans the n items of the lowest non-empty bucket for the minimum and then
// redistributes them, both bound by the single read port of the item RAM. The next request
// is accepted while a result still waits in the output register.
module monotone_radix_heap import mrh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [63:0]           key,
  input  logic [VALUE_BITS-1:0] item_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [63:0]           out_key,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [COUNT_BITS-1:0] item_count
);

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH_RD, S_PUSH_WR, S_RF_FIND, S_RF_FILL_RD, S_RF_FILL,
    S_SCAN_RD, S_SCAN_CMP, S_MOVE_RD, S_MOVE_DAT, S_MOVE_WR,
    S_POP_RD, S_POP_FILL, S_POP_DAT, S_FIN
  } state_t;

  state_t                state;
  logic [1:0]            op;
  logic [KEY_BITS-1:0]   k;
  logic [VALUE_BITS-1:0] v;
  logic [BKT_BITS-1:0]   b;
  logic [BKT_BITS-1:0]   src;
  logic [FILL_BITS-1:0]  n;
  logic [FILL_BITS-1:0]  j;
  logic [FILL_BITS-1:0]  f0;
  logic [KEY_BITS-1:0]   m;
  logic [KEY_BITS-1:0]   last;
  logic [COUNT_BITS-1:0] total;
  logic [NUM_BUCKETS-1:0] nz;
  logic                  fill_nz;
  logic [1:0]            res_status;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_value;

  logic                  d_we;
  logic [ADDR_BITS-1:0]  d_waddr, d_raddr;
  logic [WORD_BITS-1:0]  d_wdata, d_rdata;
  logic                  f_we;
  logic [BKT_BITS-1:0]   f_waddr, f_raddr;
  logic [FILL_BITS-1:0]  f_wdata, f_rdata;

  logic [FILL_BITS-1:0]  fill;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic [KEY_BITS-1:0]   m_new;
  logic [BKT_BITS-1:0]   t_comb;
  logic [BKT_BITS-1:0]   first;
  logic [FILL_BITS-1:0]  j_inc;

  assign fill     = fill_nz ? f_rdata : '0;
  assign rd_key   = d_rdata[VALUE_BITS +: KEY_BITS];
  assign rd_value = d_rdata[VALUE_BITS-1:0];
  assign m_new    = (j == '0 || rd_key < m) ? rd_key : m;
  assign t_comb   = top_bit(rd_key ^ last);
  assign j_inc    = j + FILL_BITS'(1);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    first = '0;
    for (int i = NUM_BUCKETS - 1; i >= 1; i--) begin
      if (nz[i]) first = BKT_BITS'(i);
    end
  end

  mrh_ram #(.WIDTH(WORD_BITS), .DEPTH(DATA_DEPTH), .ADDR_BITS(ADDR_BITS)) u_items (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
  );

  mrh_ram #(.WIDTH(FILL_BITS), .DEPTH(NUM_BUCKETS), .ADDR_BITS(BKT_BITS)) u_fill (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );

  always_comb begin
    d_we    = 1'b0;
    d_waddr = {b, fill[IDX_BITS-1:0]};
    d_wdata = {k, v};
    d_raddr = {src, j[IDX_BITS-1:0]};
    f_we    = 1'b0;
    f_waddr = b;
    f_wdata = fill + FILL_BITS'(1);
    f_raddr = b;
    case (state)
      S_PUSH_WR: begin
        if (fill < FILL_BITS'(BUCKET_DEPTH)) begin
          d_we = 1'b1;
          f_we = 1'b1;
        end
      end
      S_RF_FILL_RD: f_raddr = src;
      S_MOVE_DAT:   f_raddr = t_comb;
      S_MOVE_WR: begin
        d_we = 1'b1;
        f_we = 1'b1;
      end
      S_POP_RD: f_raddr = '0;
      S_POP_FILL: d_raddr = {BKT_BITS'(0), IDX_BITS'(fill - FILL_BITS'(1))};
      S_POP_DAT: begin
        f_waddr = '0;
        f_wdata = f0 - FILL_BITS'(1);
        f_we    = (op == OP_POP);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    fill_nz <= nz[f_raddr];
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      nz        <= '0;
      last      <= '0;
      total     <= '0;
    end else begin
      if (state == S_FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= operation;
            k          <= key[KEY_BITS-1:0];
            v          <= item_value;
            b          <= top_bit(key[KEY_BITS-1:0] ^ last);
            res_status <= STAT_OK;
            res_key    <= '0;
            res_value  <= '0;
            case (operation)
              OP_PUSH: state <= S_PUSH_RD;
              OP_POP, OP_PEEK: begin
                if (total == '0) begin
                  res_status <= STAT_EMPTY;
                  state      <= S_FIN;
                end else if (nz[0]) begin
                  state <= S_POP_RD;
                end else begin
                  state <= S_RF_FIND;
                end
              end
              default: begin
                nz    <= '0;
                last  <= '0;
                total <= '0;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_PUSH_RD: state <= S_PUSH_WR;
        S_PUSH_WR: begin
          if (fill < FILL_BITS'(BUCKET_DEPTH)) begin
            nz[b] <= 1'b1;
            total <= total + COUNT_BITS'(1);
          end else begin
            res_status <= STAT_OVERFLOW;
          end
          state <= S_FIN;
        end
        S_RF_FIND: begin
          src <= first;
          if (first == '0) begin
            res_status <= STAT_EMPTY;
            state      <= S_FIN;
          end else begin
            state <= S_RF_FILL_RD;
          end
        end
        S_RF_FILL_RD: state <= S_RF_FILL;
        S_RF_FILL: begin
          n     <= fill;
          j     <= '0;
          state <= S_SCAN_RD;
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          m <= m_new;
          if (j_inc == n) begin
            j       <= '0;
            nz[src] <= 1'b0;
            last    <= m_new;
            state   <= S_MOVE_RD;
          end else begin
            j     <= j_inc;
            state <= S_SCAN_RD;
          end
        end
        S_MOVE_RD: state <= S_MOVE_DAT;
        S_MOVE_DAT: begin
          k     <= rd_key;
          v     <= rd_value;
          b     <= t_comb;
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          nz[b] <= 1'b1;
          j     <= j_inc;
          state <= (j_inc == n) ? S_POP_RD : S_MOVE_RD;
        end
        S_POP_RD: state <= S_POP_FILL;
        S_POP_FILL: begin
          f0    <= fill;
          state <= S_POP_DAT;
        end
        S_POP_DAT: begin
          res_key <= rd_key;
          if (op == OP_POP) begin
            res_value <= rd_value;
            nz[0]     <= (f0 != FILL_BITS'(1));
            total     <= total - COUNT_BITS'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            status     <= res_status;
            out_key    <= 64'(res_key);
            out_value  <= res_value;
            item_count <= total;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
